// File: hdl/aesbc_pkg.sv
`default_nettype none
package aesbc_pkg;
    localparam int RK_DEPTH = 60;
    localparam int RK_ROWS = RK_DEPTH / 4;
    localparam int RK_AW = 6;
    localparam int BLK_W = 128;
    localparam logic [1:0] KLEN_128 = 2'd0;
    localparam logic [1:0] KLEN_192 = 2'd1;
    localparam logic [2:0] REG_KLEN = 3'd0;
    localparam logic [2:0] REG_KEY0 = 3'd1;
    localparam logic [2:0] REG_KEY1 = 3'd2;
    localparam logic [2:0] REG_KEY2 = 3'd3;
    localparam logic [2:0] REG_KEY3 = 3'd4;
    localparam logic CMD_ENC = 1'b0;

    typedef struct packed {
        logic       ks_start;
        logic       ks_step;
        logic       load;
        logic       round;
        logic [1:0] klen;
    } t_ctrl;

    typedef struct packed {
        logic ks_last;
        logic rnd_last;
    } t_stat;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction
endpackage
`default_nettype wire

// File: hdl/aesbc_ctrl.sv
`default_nettype none
module aesbc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_valid,
    output logic                  o_s_ready,
    output logic                  o_m_valid,
    input  wire logic             i_m_ready,
    input  wire logic             i_cfg_wr,
    input  wire logic [1:0]       i_klen,
    input  wire aesbc_pkg::t_stat i_stat,
    output aesbc_pkg::t_ctrl      o_ctrl
);
    import aesbc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_KEYS = 4'b0010,
        S_RUN  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_expanded, n_expanded;

    // expand runs first after a key write, then rounds
    always_comb begin
        n_state    = r_state;
        n_expanded = r_expanded;
        o_ctrl     = '0;
        o_ctrl.klen = i_klen;
        o_s_ready  = 1'b0;
        o_m_valid  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_ctrl.load = 1'b1;
                    if (r_expanded) begin
                        n_state = S_RUN;
                    end else begin
                        o_ctrl.ks_start = 1'b1;
                        n_state = S_KEYS;
                    end
                end
            end
            S_KEYS: begin
                o_ctrl.ks_step = 1'b1;
                if (i_stat.ks_last) begin
                    n_expanded = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_ctrl.round = 1'b1;
                if (i_stat.rnd_last) n_state = S_OUT;
            end
            S_OUT: begin
                o_m_valid = 1'b1;
                if (i_m_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_wr) n_expanded = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_expanded <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_expanded <= n_expanded;
        end
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_ready |-> !o_m_valid) else $error("ready while result held");
    a_run_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && i_stat.rnd_last) |=> o_m_valid) else $error("no result");
    a_keys_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KEYS && i_stat.ks_last && !i_cfg_wr) |=> r_expanded)
        else $error("schedule flag");
`endif
endmodule
`default_nettype wire

// File: hdl/aesbc_dp.sv
`default_nettype none
module aesbc_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire aesbc_pkg::t_ctrl    i_ctrl,
    input  wire logic [255:0]        i_key,
    input  wire logic [127:0]        i_block,
    input  wire logic                i_cmd,
    output aesbc_pkg::t_stat         o_stat,
    output logic [127:0]             o_result
);
    import aesbc_pkg::*;

    logic [127:0]     r_rk [RK_ROWS];
    logic [127:0]     r_rk_q;
    logic [31:0]      r_w [8];
    logic [RK_AW-1:0] r_wi;
    logic [3:0]       r_nk_cnt;
    logic [7:0]       r_rcon;
    logic [127:0]     r_st;
    logic             r_cmd;
    logic [3:0]       r_rnd;
    logic [3:0]       n_rnd;
    logic             r_fetch;
    logic             r_first;
    logic [3:0]       nk, nr;
    logic [2:0]       nk_last;
    logic [31:0]      t, nw;
    logic [127:0]     n_st;
    logic [RK_AW-1:0] total;
    logic             last_rnd;
    logic             rd_en;
    logic [3:0]       rd_row;

    always_comb begin
        case (i_ctrl.klen)
            KLEN_128: begin nk = 4'd4; nr = 4'd10; end
            KLEN_192: begin nk = 4'd6; nr = 4'd12; end
            default:  begin nk = 4'd8; nr = 4'd14; end
        endcase
        nk_last = 3'(nk - 4'd1);
        total = RK_AW'({nk, 2'b00} + 6'd28);
    end

    // one schedule word per cycle; window holds the last nk words
    always_comb begin
        t = r_w[nk_last];
        if (r_nk_cnt == 4'd0)
            t = sub_word({t[23:0], t[31:24]}) ^ {r_rcon, 24'h0};
        else if (nk == 4'd8 && r_nk_cnt == 4'd4)
            t = sub_word(t);
        nw = r_w[0] ^ t;
    end
    assign o_stat.ks_last = (r_wi == total - RK_AW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi     <= '0;
            r_nk_cnt <= 4'd0;
            r_rcon   <= 8'h01;
        end else if (i_ctrl.ks_start) begin
            r_wi     <= RK_AW'(nk);
            r_nk_cnt <= 4'd0;
            r_rcon   <= 8'h01;
        end else if (i_ctrl.ks_step) begin
            r_wi <= r_wi + RK_AW'(1);
            if (r_nk_cnt == nk - 4'd1) r_nk_cnt <= 4'd0;
            else r_nk_cnt <= r_nk_cnt + 4'd1;
            if (r_nk_cnt == 4'd0) r_rcon <= xt(r_rcon);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ks_start) begin
            for (int i = 0; i < 8; i++) r_w[i] <= i_key[255 - 32*i -: 32];
        end else if (i_ctrl.ks_step) begin
            for (int i = 0; i < 7; i++) begin
                if (4'(i) == nk - 4'd1) r_w[i] <= nw;
                else r_w[i] <= r_w[i+1];
            end
            r_w[7] <= nw;
        end
    end

    // key store, four schedule words per row, one registered row read a cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ks_start) begin
            r_rk[0] <= i_key[255:128];
            r_rk[1] <= i_key[127:0];
        end else if (i_ctrl.ks_step) begin
            r_rk[r_wi[RK_AW-1:2]][{~r_wi[1:0], 5'd0} +: 32] <= nw;
        end
        if (rd_en) r_rk_q <= r_rk[rd_row];
    end

    // row wanted by the next cycle's step
    always_comb begin
        if (r_fetch)      rd_row = (r_cmd == CMD_ENC) ? 4'd0 : nr;
        else if (r_first) rd_row = (r_cmd == CMD_ENC) ? 4'd1 : nr - 4'd1;
        else              rd_row = n_rnd;
        rd_en = i_ctrl.round & (r_fetch | r_first | !last_rnd);
    end

    function automatic logic [31:0] mix(input logic [31:0] c, input logic inv);
        logic [7:0] a [4];
        logic [7:0] o [4];
        logic [7:0] x2, x4, x8;
        for (int j = 0; j < 4; j++) a[j] = c[31 - 8*j -: 8];
        for (int r = 0; r < 4; r++) begin
            o[r] = 8'h0;
            for (int j = 0; j < 4; j++) begin
                x2 = xt(a[j]); x4 = xt(x2); x8 = xt(x4);
                case ((j + 4 - r) & 3)
                    0: o[r] ^= inv ? (x8 ^ x4 ^ x2) : x2;
                    1: o[r] ^= inv ? (x8 ^ x2 ^ a[j]) : (x2 ^ a[j]);
                    2: o[r] ^= inv ? (x8 ^ x4 ^ a[j]) : a[j];
                    default: o[r] ^= inv ? (x8 ^ a[j]) : a[j];
                endcase
            end
        end
        return {o[0], o[1], o[2], o[3]};
    endfunction

    // one full round per cycle
    always_comb begin
        logic [7:0] s [16];
        logic [7:0] u [16];
        logic [127:0] v;
        for (int i = 0; i < 16; i++) s[i] = r_st[127 - 8*i -: 8];
        last_rnd = (r_rnd == (r_cmd ? 4'd0 : nr));
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                if (r_cmd) u[r + 4*((c + r) & 3)] = inv_sbox(s[r + 4*c]);
                else       u[r + 4*c] = sbox(s[r + 4*((c + r) & 3)]);
            end
        for (int i = 0; i < 16; i++) v[127 - 8*i -: 8] = u[i];
        if (r_cmd) begin
            v = v ^ r_rk_q;
            if (!last_rnd)
                for (int c = 0; c < 4; c++) v[127 - 32*c -: 32] = mix(v[127 - 32*c -: 32], 1'b1);
        end else begin
            if (!last_rnd)
                for (int c = 0; c < 4; c++) v[127 - 32*c -: 32] = mix(v[127 - 32*c -: 32], 1'b0);
            v = v ^ r_rk_q;
        end
        n_st = v;
        n_rnd = r_cmd ? r_rnd - 4'd1 : r_rnd + 4'd1;
        o_stat.rnd_last = last_rnd & !r_fetch & !r_first;
    end

    // fetch cycle, initial add-round-key cycle, then the rounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= '0;
            r_cmd   <= CMD_ENC;
            r_rnd   <= 4'd0;
            r_fetch <= 1'b0;
            r_first <= 1'b0;
        end else if (i_ctrl.load) begin
            r_st    <= i_block;
            r_cmd   <= i_cmd;
            r_fetch <= 1'b1;
            r_first <= 1'b1;
        end else if (i_ctrl.round) begin
            if (r_fetch) begin
                r_fetch <= 1'b0;
            end else if (r_first) begin
                r_st    <= r_st ^ r_rk_q;
                r_rnd   <= (r_cmd == CMD_ENC) ? 4'd1 : nr - 4'd1;
                r_first <= 1'b0;
            end else begin
                r_st  <= n_st;
                r_rnd <= n_rnd;
            end
        end
    end

    assign o_result = r_st;
endmodule
`default_nettype wire

// File: hdl/aes_block_cipher_top.sv
// aes block cipher, 128/192/256-bit keys, ecb
// input channel: s_axis word = block_upper, block_lower (tdata), command (tuser)
// output channel: m_axis word = result_upper, result_lower
// key registers via apb: 0 key length, 1..4 key bits (64-bit, byte addr 8*i)
// any key register write marks the schedule stale; the next word first
// expands the key, one schedule word per cycle, 44/52/60 words of which
// the first nk are taken from the key at the start
// per word: an accept state, a round key fetch, an initial
// add-round-key step, one round per cycle over 10/12/14 rounds and an
// output state that holds until the result is taken
// one word at a time: s_tready high only while idle
// when the receiver stalls the result holds in the state register with
// m_tvalid high until taken
// reset: synchronous active low; clears controller and registers,
// schedule is rebuilt on the first word
// round keys sit in a 15-row store of four schedule words each; no
// clearing pass, it is always written before read
`default_nettype none
module aes_block_cipher_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // block_upper [63:0], block_lower [127:64]
    input  wire logic         s_axis_tuser,   // command
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,   // result_upper [63:0], result_lower [127:64]
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    import aesbc_pkg::*;

    logic [1:0]  r_klen;
    logic [63:0] r_key [4];
    logic        cfg_wr;
    logic [2:0]  ridx;
    t_ctrl       ctrl;
    t_stat       stat;
    logic [127:0] res;

    assign pready = 1'b1;
    assign ridx   = paddr[5:3];
    assign cfg_wr = psel & penable & pwrite & (ridx <= REG_KEY3) & (paddr[2:0] == 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen <= '0;
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
        end else if (cfg_wr) begin
            case (ridx)
                REG_KLEN: r_klen <= pwdata[1:0];
                REG_KEY0: r_key[0] <= pwdata;
                REG_KEY1: r_key[1] <= pwdata;
                REG_KEY2: r_key[2] <= pwdata;
                REG_KEY3: r_key[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_KLEN: prdata = {62'h0, r_klen};
            REG_KEY0: prdata = r_key[0];
            REG_KEY1: prdata = r_key[1];
            REG_KEY2: prdata = r_key[2];
            REG_KEY3: prdata = r_key[3];
            default:  prdata = '0;
        endcase
    end

    aesbc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .o_s_ready(s_axis_tready),
        .o_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready),
        .i_cfg_wr(cfg_wr), .i_klen(r_klen), .i_stat(stat), .o_ctrl(ctrl)
    );

    aesbc_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl),
        .i_key({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_block({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .i_cmd(s_axis_tuser), .o_stat(stat), .o_result(res)
    );

    assign m_axis_tdata = {res[63:0], res[127:64]};
endmodule
`default_nettype wire
